>>> sv/fdc_pkg.sv
// shared types and constants for the frame deframer with crc-16 trailer
`timescale 1ns / 1ps
package fdc_pkg;

    localparam int unsigned HDR_BYTES      = 7;
    localparam int unsigned FRAME_OVERHEAD = 9;
    localparam int unsigned POS_W          = 17;
    localparam logic [POS_W-1:0] POS_MAX   = 17'h1FFFF;
    localparam logic [8:0]  COUNT_MAX      = 9'd511;
    localparam logic [15:0] CRC_INIT       = 16'hFFFF;
    localparam logic [15:0] CRC_POLY       = 16'h1021;
    localparam logic [7:0]  VERSION_RESET  = 8'd1;

    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_SHORT      = 3'd1,
        ST_BAD_VER    = 3'd2,
        ST_LEN_OVER   = 3'd3,
        ST_LEN_MISM   = 3'd4,
        ST_CRC_MISM   = 3'd5
    } t_status;

    typedef struct packed {
        logic        is_verdict;
        logic [7:0]  payload_byte;
        logic [7:0]  frame_type;
        logic [7:0]  frame_flags;
        logic [15:0] sequence_number;
        logic [8:0]  payload_count;
        t_status     status;
    } t_result;

endpackage

>>> sv/fdc_crc.sv
// crc-16/ccitt-false update over one byte, msb first
`timescale 1ns / 1ps
module fdc_crc (
    input  logic [15:0] i_crc,
    input  logic [7:0]  i_byte,
    output logic [15:0] o_crc
);
    import fdc_pkg::*;

    always_comb begin
        logic [15:0] c;
        c = i_crc ^ {i_byte, 8'h00};
        for (int k = 0; k < 8; k++) begin
            if (c[15]) begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[14:0], 1'b0};
            end
        end
        o_crc = c;
    end

endmodule

>>> sv/fdc_out_buf.sv
// two-entry result buffer between the frame logic and the output channel
`timescale 1ns / 1ps
module fdc_out_buf (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  fdc_pkg::t_result i_data,
    output logic             o_full,
    output logic             o_valid,
    input  logic             i_pop,
    output fdc_pkg::t_result o_data
);
    import fdc_pkg::*;

    t_result    r_mem [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;
    logic       pop_fire;

    assign o_full   = (r_count == 2'd2);
    assign o_valid  = (r_count != 2'd0);
    assign pop_fire = o_valid && i_pop;
    assign o_data   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (pop_fire) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            unique case ({i_push, pop_fire})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

>>> sv/frame_deframer_crc16_unit.sv
// top level: frame byte parser, header capture, crc check and verdict
// one byte beat is accepted per cycle unless the output buffer is full; frame state and crc update sit in one pass
// a result enters the output buffer at its accepting edge and is offered the next cycle
// input stalls only while both entries of the two-entry output buffer hold results
// reset is synchronous, active low; it clears frame state and sets the version to 1
`timescale 1ns / 1ps
module frame_deframer_crc16_unit #(
    parameter int unsigned MAX_PAYLOAD = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_data_byte,
    input  logic        i_last_byte,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic        o_is_verdict,
    output logic [7:0]  o_payload_byte,
    output logic [7:0]  o_frame_type,
    output logic [7:0]  o_frame_flags,
    output logic [15:0] o_sequence_number,
    output logic [8:0]  o_payload_count,
    output logic [2:0]  o_status,
    input  logic        i_cfg_we,
    input  logic [7:0]  i_cfg_data
);
    import fdc_pkg::*;

    localparam logic [15:0] MAX_LEN = 16'(MAX_PAYLOAD);

    logic [7:0]       r_exp_ver;
    logic [POS_W-1:0] r_pos,  n_pos;
    logic [15:0]      r_crc,  n_crc;
    logic [15:0]      r_rcv,  n_rcv;
    logic [7:0]       r_type, n_type;
    logic [7:0]       r_flags, n_flags;
    logic [15:0]      r_seq,  n_seq;
    logic [15:0]      r_len,  n_len;
    t_status          r_err,  n_err;

    logic [15:0]      crc_upd;
    logic             in_fire;
    logic             buf_full;
    logic             payload_hit;
    logic             push;
    logic [POS_W-1:0] count;
    t_status          verdict_status;
    t_result          result;
    t_result          out_data;

    fdc_crc u_crc (
        .i_crc  (r_crc),
        .i_byte (r_rcv[7:0]),
        .o_crc  (crc_upd)
    );

    assign o_in_ready = !buf_full;
    assign in_fire    = i_in_valid && o_in_ready;

    always_comb begin
        n_crc   = (r_pos >= POS_W'(2)) ? crc_upd : r_crc;
        n_rcv   = {i_data_byte, r_rcv[15:8]};
        n_type  = r_type;
        n_flags = r_flags;
        n_seq   = r_seq;
        n_len   = r_len;
        n_err   = r_err;
        unique case (r_pos)
            POS_W'(0): begin
                if (i_data_byte != r_exp_ver) begin
                    n_err = ST_BAD_VER;
                end
            end
            POS_W'(1): n_type  = i_data_byte;
            POS_W'(2): n_flags = i_data_byte;
            POS_W'(3): n_seq   = {8'h00, i_data_byte};
            POS_W'(4): n_seq   = {i_data_byte, r_seq[7:0]};
            POS_W'(5): n_len   = {8'h00, i_data_byte};
            POS_W'(6): begin
                n_len = {i_data_byte, r_len[7:0]};
                if (r_err == ST_OK && n_len > MAX_LEN) begin
                    n_err = ST_LEN_OVER;
                end
            end
            default: ;
        endcase

        n_pos = (r_pos < POS_MAX) ? r_pos + POS_W'(1) : r_pos;
        count = n_pos;

        priority if (count < POS_W'(FRAME_OVERHEAD)) begin
            verdict_status = ST_SHORT;
        end else if (n_err != ST_OK) begin
            verdict_status = n_err;
        end else if (count != POS_W'(FRAME_OVERHEAD) + {1'b0, n_len}) begin
            verdict_status = ST_LEN_MISM;
        end else if (n_rcv != n_crc) begin
            verdict_status = ST_CRC_MISM;
        end else begin
            verdict_status = ST_OK;
        end

        // payload window lies between the header and the declared length
        payload_hit = (n_err == ST_OK) && (r_pos >= POS_W'(HDR_BYTES))
                      && (r_pos < POS_W'(HDR_BYTES) + {1'b0, n_len});

        if (i_last_byte) begin
            result.is_verdict      = 1'b1;
            result.payload_byte    = 8'h00;
            result.frame_type      = n_type;
            result.frame_flags     = n_flags;
            result.sequence_number = n_seq;
            result.payload_count   = (n_len > 16'(COUNT_MAX)) ? COUNT_MAX : n_len[8:0];
            result.status          = verdict_status;
        end else begin
            result.is_verdict      = 1'b0;
            result.payload_byte    = i_data_byte;
            result.frame_type      = 8'h00;
            result.frame_flags     = 8'h00;
            result.sequence_number = 16'h0000;
            result.payload_count   = 9'd0;
            result.status          = ST_OK;
        end

        push = in_fire && (i_last_byte || payload_hit);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_exp_ver <= VERSION_RESET;
        end else if (i_cfg_we) begin
            r_exp_ver <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= '0;
            r_crc   <= CRC_INIT;
            r_rcv   <= '0;
            r_type  <= '0;
            r_flags <= '0;
            r_seq   <= '0;
            r_len   <= '0;
            r_err   <= ST_OK;
        end else if (in_fire) begin
            if (i_last_byte) begin
                // verdict ends the frame, back to the start-of-frame state
                r_pos   <= '0;
                r_crc   <= CRC_INIT;
                r_rcv   <= '0;
                r_type  <= '0;
                r_flags <= '0;
                r_seq   <= '0;
                r_len   <= '0;
                r_err   <= ST_OK;
            end else begin
                r_pos   <= n_pos;
                r_crc   <= n_crc;
                r_rcv   <= n_rcv;
                r_type  <= n_type;
                r_flags <= n_flags;
                r_seq   <= n_seq;
                r_len   <= n_len;
                r_err   <= n_err;
            end
        end
    end

    fdc_out_buf u_out_buf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (result),
        .o_full  (buf_full),
        .o_valid (o_out_valid),
        .i_pop   (i_out_ready),
        .o_data  (out_data)
    );

    assign o_is_verdict      = out_data.is_verdict;
    assign o_payload_byte    = out_data.payload_byte;
    assign o_frame_type      = out_data.frame_type;
    assign o_frame_flags     = out_data.frame_flags;
    assign o_sequence_number = out_data.sequence_number;
    assign o_payload_count   = out_data.payload_count;
    assign o_status          = out_data.status;

endmodule

>>> sv/fdc_checker.sv
// port-level checks for the frame deframer and the bind that attaches them
`timescale 1ns / 1ps
module fdc_checker #(
    parameter int unsigned MAX_PAYLOAD = 256
) (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic        o_is_verdict,
    input logic [7:0]  o_payload_byte,
    input logic [7:0]  o_frame_type,
    input logic [7:0]  o_frame_flags,
    input logic [15:0] o_sequence_number,
    input logic [8:0]  o_payload_count,
    input logic [2:0]  o_status
);
    import fdc_pkg::*;

    // no result survives a reset
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    a_payload_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_is_verdict) |-> (o_frame_type == 8'h00 && o_frame_flags == 8'h00
            && o_sequence_number == 16'h0000 && o_payload_count == 9'd0
            && o_status == ST_OK))
        else $error("payload beat carries verdict fields");

    a_verdict_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_is_verdict) |-> (o_payload_byte == 8'h00
            && o_status != 3'd6 && o_status != 3'd7))
        else $error("verdict beat malformed");

    // an ok frame never declares more payload than allowed
    a_ok_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_is_verdict && o_status == ST_OK)
            |-> (32'(o_payload_count) <= 32'(MAX_PAYLOAD)))
        else $error("ok verdict with length over maximum");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_status)
            && $stable(o_payload_byte) && $stable(o_is_verdict)))
        else $error("stalled output beat changed");

endmodule

bind frame_deframer_crc16_unit fdc_checker #(.MAX_PAYLOAD(MAX_PAYLOAD)) u_fdc_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .o_out_valid       (o_out_valid),
    .i_out_ready       (i_out_ready),
    .o_is_verdict      (o_is_verdict),
    .o_payload_byte    (o_payload_byte),
    .o_frame_type      (o_frame_type),
    .o_frame_flags     (o_frame_flags),
    .o_sequence_number (o_sequence_number),
    .o_payload_count   (o_payload_count),
    .o_status          (o_status)
);

>>> sim/tb.sv
// self-checking testbench for the frame deframer with crc-16 trailer
`timescale 1ns / 1ps
module tb;
    import fdc_pkg::*;

    localparam int unsigned MAX_PAYLOAD  = 256;
    localparam int unsigned STALL_CYCLES = 80;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } t_tx_beat;

    logic        i_clk          = 1'b0;
    logic        i_rst_n        = 1'b0;
    logic        i_in_valid     = 1'b0;
    logic        o_in_ready;
    logic [7:0]  i_data_byte    = 8'h00;
    logic        i_last_byte    = 1'b0;
    logic        o_out_valid;
    logic        i_out_ready    = 1'b0;
    logic        o_is_verdict;
    logic [7:0]  o_payload_byte;
    logic [7:0]  o_frame_type;
    logic [7:0]  o_frame_flags;
    logic [15:0] o_sequence_number;
    logic [8:0]  o_payload_count;
    logic [2:0]  o_status;
    logic        i_cfg_we       = 1'b0;
    logic [7:0]  i_cfg_data     = 8'h00;

    frame_deframer_crc16_unit #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) i_dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_ready        (o_in_ready),
        .i_data_byte       (i_data_byte),
        .i_last_byte       (i_last_byte),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .o_is_verdict      (o_is_verdict),
        .o_payload_byte    (o_payload_byte),
        .o_frame_type      (o_frame_type),
        .o_frame_flags     (o_frame_flags),
        .o_sequence_number (o_sequence_number),
        .o_payload_count   (o_payload_count),
        .o_status          (o_status),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_data        (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // stimulus and scoreboard storage
    t_tx_beat   tx_bytes[$];
    logic [7:0] frame_buf[$];
    t_result    expected_results[$];
    int         bytes_queued = 0;
    int         error_count  = 0;
    int         payload_hits = 0;
    int         status_hits[6];
    int         version_writes = 0;
    bit         idle_on = 1'b1;
    bit         in_took = 1'b0;
    int         send_gap = 0;
    int         rx_gap = 0;
    int         hold_left = 0;
    int         stall_req = 0;
    int         stall_seen = 0;

    // predictor state
    logic [7:0]  cfg_version = VERSION_RESET;
    logic [16:0] pos_q       = '0;
    logic [15:0] crc_run     = CRC_INIT;
    logic [15:0] crc_rx      = '0;
    logic [7:0]  hdr_type    = '0;
    logic [7:0]  hdr_flags   = '0;
    logic [15:0] hdr_seq     = '0;
    logic [15:0] hdr_len     = '0;
    t_status     err_q       = ST_OK;

    function automatic logic [15:0] crc16_update(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        int          k;
        c = crc ^ {b, 8'h00};
        for (k = 0; k < 8; k++)
            c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
        return c;
    endfunction

    function automatic void clear_frame_state();
        pos_q     = '0;
        crc_run   = CRC_INIT;
        crc_rx    = '0;
        hdr_type  = '0;
        hdr_flags = '0;
        hdr_seq   = '0;
        hdr_len   = '0;
        err_q     = ST_OK;
    endfunction

    // advances the frame state by one byte; returns 1 when the byte yields a result
    function automatic bit deframe_byte(input logic [7:0] b, input logic last,
                                        output t_result r);
        logic [16:0] pos;
        int unsigned count;
        t_status     st;
        pos = pos_q;
        r   = '0;
        // crc trails the input by two bytes so the trailer never enters it
        if (pos >= 17'd2)
            crc_run = crc16_update(crc_run, crc_rx[7:0]);
        crc_rx = {b, crc_rx[15:8]};
        case (pos)
            17'd0: if (b != cfg_version) err_q = ST_BAD_VER;
            17'd1: hdr_type = b;
            17'd2: hdr_flags = b;
            17'd3: hdr_seq = {8'h00, b};
            17'd4: hdr_seq[15:8] = b;
            17'd5: hdr_len = {8'h00, b};
            17'd6: begin
                hdr_len[15:8] = b;
                if (err_q == ST_OK && 32'(hdr_len) > MAX_PAYLOAD)
                    err_q = ST_LEN_OVER;
            end
            default: ;
        endcase
        if (last) begin
            count = (pos < POS_MAX) ? 32'(pos) + 1 : 32'(POS_MAX);
            if (count < FRAME_OVERHEAD)
                st = ST_SHORT;
            else if (err_q != ST_OK)
                st = err_q;
            else if (count != FRAME_OVERHEAD + 32'(hdr_len))
                st = ST_LEN_MISM;
            else if (crc_rx != crc_run)
                st = ST_CRC_MISM;
            else
                st = ST_OK;
            r.is_verdict      = 1'b1;
            r.frame_type      = hdr_type;
            r.frame_flags     = hdr_flags;
            r.sequence_number = hdr_seq;
            r.payload_count   = (hdr_len > 16'(COUNT_MAX)) ? COUNT_MAX : hdr_len[8:0];
            r.status          = st;
            clear_frame_state();
            return 1'b1;
        end
        if (pos < POS_MAX)
            pos_q = pos + 17'd1;
        if (err_q == ST_OK && 32'(pos) >= HDR_BYTES && 32'(pos) < HDR_BYTES + 32'(hdr_len)) begin
            r.payload_byte = b;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    task automatic flag_error(input string msg);
        $display("[%0t] mismatch: %s", $realtime, msg);
        error_count++;
    endtask

    task automatic check_field(input string name, input logic [31:0] got, input logic [31:0] want);
        if (got !== want)
            flag_error($sformatf("%s got %0h want %0h", name, got, want));
    endtask

    // frame image: header, payload, little-endian crc over everything before it
    task automatic build_frame(input logic [7:0] ver, input logic [7:0] ftype,
                               input logic [7:0] flags, input logic [15:0] seq,
                               input logic [15:0] len, input int npay);
        logic [15:0] crc;
        int          i;
        frame_buf.delete();
        frame_buf.push_back(ver);
        frame_buf.push_back(ftype);
        frame_buf.push_back(flags);
        frame_buf.push_back(seq[7:0]);
        frame_buf.push_back(seq[15:8]);
        frame_buf.push_back(len[7:0]);
        frame_buf.push_back(len[15:8]);
        for (i = 0; i < npay; i++)
            frame_buf.push_back(8'($urandom));
        crc = CRC_INIT;
        foreach (frame_buf[i])
            crc = crc16_update(crc, frame_buf[i]);
        frame_buf.push_back(crc[7:0]);
        frame_buf.push_back(crc[15:8]);
    endtask

    task automatic truncate_frame(input int n);
        while (frame_buf.size() > n)
            void'(frame_buf.pop_back());
    endtask

    task automatic commit_frame();
        t_tx_beat beat;
        foreach (frame_buf[i]) begin
            beat.data = frame_buf[i];
            beat.last = (i == frame_buf.size() - 1);
            tx_bytes.push_back(beat);
        end
        bytes_queued += frame_buf.size();
    endtask

    // mostly well-formed frames, the rest broken in one way or another
    task automatic queue_random_frame();
        int          pick;
        int          npay;
        int          idx;
        logic [15:0] len;
        logic [7:0]  ver;
        pick = $urandom_range(0, 99);
        ver  = cfg_version;
        len  = ($urandom_range(0, 19) == 0) ? 16'($urandom_range(13, MAX_PAYLOAD))
                                            : 16'($urandom_range(0, 12));
        npay = int'(len);
        if (pick >= 94) begin
            frame_buf.delete();
            repeat ($urandom_range(1, 20)) frame_buf.push_back(8'($urandom));
        end else begin
            if (pick >= 81 && pick < 87) begin
                len  = 16'($urandom_range(MAX_PAYLOAD + 1, 65535));
                npay = $urandom_range(0, 4);
            end else if (pick >= 75 && pick < 81) begin
                ver = cfg_version ^ 8'($urandom_range(1, 255));
            end else if (pick >= 68 && pick < 75) begin
                if (len != 0 && $urandom_range(0, 1) == 1)
                    npay = int'(len) - $urandom_range(1, int'(len));
                else
                    npay = int'(len) + $urandom_range(1, 6);
            end
            build_frame(ver, 8'($urandom), 8'($urandom), 16'($urandom), len, npay);
            if (pick >= 60 && pick < 68) begin
                idx = frame_buf.size() - 1 - $urandom_range(0, 1);
                frame_buf[idx] = frame_buf[idx] ^ 8'($urandom_range(1, 255));
            end else if (pick >= 87) begin
                truncate_frame($urandom_range(1, 8));
            end
        end
        commit_frame();
    endtask

    task automatic queue_random_bytes(input int n);
        int target;
        target = bytes_queued + n;
        while (bytes_queued < target)
            queue_random_frame();
    endtask

    task automatic wait_drained();
        while (tx_bytes.size() != 0 || i_in_valid || expected_results.size() != 0)
            @(posedge i_clk);
        // bytes without a result may still be in flight
        repeat (4) @(posedge i_clk);
    endtask

    task automatic set_version(input logic [7:0] v);
        @(negedge i_clk);
        i_cfg_data  <= v;
        i_cfg_we    <= 1'b1;
        cfg_version  = v;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        version_writes++;
    endtask

    // sender: new beat only once the previous one was taken
    always @(negedge i_clk) begin : sender
        t_tx_beat beat;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || in_took) begin
            if (send_gap != 0) begin
                send_gap = send_gap - 1;
                i_in_valid <= 1'b0;
            end else if (tx_bytes.size() != 0 && idle_on && $urandom_range(0, 11) == 0) begin
                send_gap = $urandom_range(1, 11) - 1;
                i_in_valid <= 1'b0;
            end else if (tx_bytes.size() != 0) begin
                beat = tx_bytes.pop_front();
                i_data_byte <= beat.data;
                i_last_byte <= beat.last;
                i_in_valid  <= 1'b1;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    always @(negedge i_clk) begin : receiver
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else if (stall_seen != stall_req) begin
            stall_seen = stall_req;
            hold_left  = STALL_CYCLES - 1;
            i_out_ready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left = hold_left - 1;
            i_out_ready <= 1'b0;
        end else if (rx_gap != 0) begin
            rx_gap = rx_gap - 1;
            i_out_ready <= 1'b0;
        end else if (idle_on && $urandom_range(0, 7) == 0) begin
            rx_gap = $urandom_range(1, 11) - 1;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin : monitor
        t_result fresh;
        t_result want;
        if (!i_rst_n) begin
            in_took = 1'b0;
            clear_frame_state();
            expected_results.delete();
        end else begin
            in_took = i_in_valid && o_in_ready;
            if (in_took && deframe_byte(i_data_byte, i_last_byte, fresh))
                expected_results.push_back(fresh);
            if (o_out_valid && i_out_ready) begin
                if (expected_results.size() == 0) begin
                    flag_error("result beat with nothing expected");
                end else begin
                    want = expected_results.pop_front();
                    check_field("is_verdict", o_is_verdict, want.is_verdict);
                    check_field("payload_byte", o_payload_byte, want.payload_byte);
                    check_field("frame_type", o_frame_type, want.frame_type);
                    check_field("frame_flags", o_frame_flags, want.frame_flags);
                    check_field("sequence_number", o_sequence_number, want.sequence_number);
                    check_field("payload_count", o_payload_count, want.payload_count);
                    check_field("status", o_status, want.status);
                    if (want.is_verdict)
                        status_hits[int'(want.status)]++;
                    else
                        payload_hits++;
                end
            end
        end
    end

    initial begin : stimulus
        logic [7:0] v;
        int         i;
        int         guard;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        v = cfg_version;

        // directed frames at the reset version
        build_frame(v, 8'h00, 8'hFF, 16'h0000, 16'd0, 0);
        commit_frame();
        build_frame(v, 8'hFF, 8'h00, 16'hFFFF, 16'd3, 3);
        commit_frame();
        build_frame(v, 8'hA5, 8'h5A, 16'h1234, 16'd1, 1);
        truncate_frame(1);
        commit_frame();
        build_frame(v, 8'h3C, 8'hC3, 16'h8001, 16'd1, 1);
        truncate_frame(8);
        commit_frame();
        build_frame(~v, 8'h11, 8'h22, 16'h4433, 16'd2, 2);
        commit_frame();
        build_frame(v, 8'h12, 8'h34, 16'h7FFF, 16'(MAX_PAYLOAD + 1), 3);
        commit_frame();
        // wrong version wins over an oversized length
        build_frame(~v, 8'h55, 8'hAA, 16'h0101, 16'd300, 2);
        commit_frame();
        // too short wins over wrong version
        build_frame(~v, 8'h66, 8'h99, 16'hFEFE, 16'd5, 5);
        truncate_frame(4);
        commit_frame();
        // reported length clamps at the count width
        build_frame(v, 8'h01, 8'h02, 16'h0304, 16'h01FF, 0);
        commit_frame();
        build_frame(v, 8'h05, 8'h06, 16'h0708, 16'h0200, 1);
        commit_frame();
        build_frame(v, 8'h09, 8'h0A, 16'h0B0C, 16'hFFFF, 0);
        commit_frame();
        build_frame(v, 8'h80, 8'h7F, 16'h00FF, 16'(MAX_PAYLOAD), MAX_PAYLOAD);
        commit_frame();
        // payload shorter and longer than declared
        build_frame(v, 8'h21, 8'h43, 16'h6587, 16'd4, 2);
        commit_frame();
        build_frame(v, 8'h21, 8'h43, 16'h6587, 16'd4, 6);
        commit_frame();
        build_frame(v, 8'hDE, 8'hAD, 16'hBEEF, 16'd5, 5);
        frame_buf[frame_buf.size() - 1] = frame_buf[frame_buf.size() - 1] ^ 8'h01;
        commit_frame();
        build_frame(v, 8'hDE, 8'hAD, 16'hBEEF, 16'd5, 5);
        frame_buf[frame_buf.size() - 2] = frame_buf[frame_buf.size() - 2] ^ 8'h80;
        commit_frame();
        wait_drained();

        // receiver holds off while the sender keeps pushing payload
        stall_req = stall_req + 1;
        for (i = 0; i < 2; i++) begin
            build_frame(v, 8'($urandom), 8'($urandom), 16'($urandom), 16'd24, 24);
            commit_frame();
        end
        queue_random_bytes(25);
        wait_drained();

        set_version(8'h00);
        queue_random_bytes(25);
        wait_drained();

        set_version(8'hFF);
        stall_req = stall_req + 1;
        queue_random_bytes(25);
        wait_drained();

        set_version(8'($urandom));
        queue_random_bytes(25);
        wait_drained();

        // closing stretch with no idling
        idle_on = 1'b0;
        set_version(VERSION_RESET);
        queue_random_bytes(40);

        while (tx_bytes.size() != 0 || i_in_valid)
            @(posedge i_clk);
        for (guard = 0; guard < 2000 && expected_results.size() != 0; guard++)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (expected_results.size() != 0)
            flag_error($sformatf("%0d expected results never arrived", expected_results.size()));

        $display("covered %0d byte beats, %0d payload beats, %0d version writes",
                 bytes_queued, payload_hits, version_writes);
        $display("verdicts: ok %0d short %0d version %0d over %0d length %0d crc %0d",
                 status_hits[0], status_hits[1], status_hits[2], status_hits[3],
                 status_hits[4], status_hits[5]);
        if (error_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    initial begin : watchdog
        #6_000_000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule

>>> files.f
sv/fdc_pkg.sv
sv/fdc_crc.sv
sv/fdc_out_buf.sv
sv/frame_deframer_crc16_unit.sv
sv/fdc_checker.sv
sim/tb.sv
